// File: rtl/command_byte_frame_receiver_top_assert.svh
// Assertion macros for the command byte frame receiver.
`ifndef COMMAND_BYTE_FRAME_RECEIVER_TOP_ASSERT_SVH
`define COMMAND_BYTE_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CBFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbfr assertion failed");

// Next-cycle implication, disabled during reset.
`define CBFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbfr assertion failed");

`endif

// File: rtl/cbfr_pkg.sv
// Types and constants for the command byte frame receiver.
package cbfr_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHOW
  } cbfr_state_t;

  localparam logic [7:0] CMD_NONE         = 8'h80;
  localparam logic [7:0] CMD_SET_TIME     = 8'h81;
  localparam logic [7:0] CMD_RECV_TIME    = 8'h82;
  localparam logic [7:0] CMD_COLOUR_FIRST = 8'h83;
  localparam logic [7:0] CMD_COLOUR_LAST  = 8'h86;

  localparam logic [2:0] TGT_TIME = 3'd0;

  localparam int CNT_W = 4;

endpackage

// File: rtl/cbfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cbfr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds between reads
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/command_byte_frame_receiver_top.sv
// Top level of the command byte frame receiver: command decode, record stores, byte emitter.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  rx      | in_valid, in_ready, rx_byte                     | in
//  record  | out_valid, out_ready, target, byte_index,       | out
//          | byte_value, last_byte                           |
//
// An emitting item (set-time, or the byte that completes a colour record)
// is accepted in ST_IDLE; ST_READ then issues the first RAM read, and ST_SHOW
// sends one byte per cycle while out_ready is high, the next read
// overlapping the handoff.
// No new item is taken while a record is being emitted.
// Reset (rst, synchronous) clears command, count and the time-store valid
// bits; an invalid time entry reads as zero. The colour store is not cleared.
`include "command_byte_frame_receiver_top_assert.svh"

module command_byte_frame_receiver_top
  import cbfr_pkg::*;
#(
  parameter int TIME_RECORD_BYTES = 8,
  parameter int COLOR_BYTES       = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] target,
  output logic [2:0] byte_index,
  output logic [7:0] byte_value,
  output logic       last_byte
);

  localparam int TAW = (TIME_RECORD_BYTES > 1) ? $clog2(TIME_RECORD_BYTES) : 1;
  localparam int CAW = (COLOR_BYTES > 1) ? $clog2(COLOR_BYTES) : 1;

  // control state
  cbfr_state_t            state, state_next;
  logic [7:0]             cmd, cmd_next;
  logic [CNT_W-1:0]       cnt, cnt_next;
  logic [TIME_RECORD_BYTES-1:0] time_vld;

  // emitter payload
  logic [2:0]             idx, idx_next;
  logic [2:0]             tgt, tgt_next;
  logic                   rd_vld;

  logic                   in_acc, out_acc;
  logic                   is_cmd, is_colour;
  logic [CNT_W-1:0]       cnt_inc;
  logic                   time_we, col_we;
  logic                   time_done, col_done, start_time;
  logic                   last;
  logic                   rd_en;
  logic [2:0]             rd_idx;
  logic [7:0]             col_wdata;
  logic [7:0]             t_rdata, c_rdata;

  assign in_acc    = in_valid & in_ready;
  assign out_acc   = out_valid & out_ready;
  assign is_cmd    = rx_byte[7];
  assign is_colour = (cmd >= CMD_COLOUR_FIRST) && (cmd <= CMD_COLOUR_LAST);
  assign cnt_inc   = cnt + CNT_W'(1);

  assign time_we   = in_acc && !is_cmd && (cmd == CMD_RECV_TIME) &&
                     (cnt < CNT_W'(TIME_RECORD_BYTES));
  assign col_we    = in_acc && !is_cmd && is_colour &&
                     (cnt < CNT_W'(COLOR_BYTES));
  assign time_done = time_we && (cnt_inc >= CNT_W'(TIME_RECORD_BYTES));
  assign col_done  = col_we && (cnt_inc >= CNT_W'(COLOR_BYTES));
  assign start_time = in_acc && is_cmd && (rx_byte == CMD_SET_TIME);

  // zero stays zero, else (d<<1)+1
  assign col_wdata = (rx_byte == 8'd0) ? 8'd0 : {rx_byte[6:0], 1'b1};

  assign last = (tgt == TGT_TIME) ? (idx == 3'(TIME_RECORD_BYTES - 1))
                                  : (idx == 3'(COLOR_BYTES - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start_time || col_done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_acc && last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    rd_en     = 1'b0;
    rd_idx    = idx;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_READ: begin
        rd_en = 1'b1;
      end
      ST_SHOW: begin
        out_valid = 1'b1;
        // prefetch the next byte as the current one is taken
        if (out_acc && !last) begin
          rd_en  = 1'b1;
          rd_idx = idx + 3'd1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // command, count and emit index
  always_comb begin
    cmd_next = cmd;
    cnt_next = cnt;
    idx_next = idx;
    tgt_next = tgt;
    if (in_acc && is_cmd) begin
      cmd_next = rx_byte;
      cnt_next = '0;
    end else if (time_we) begin
      if (time_done) begin
        cmd_next = CMD_NONE;
        cnt_next = '0;
      end else begin
        cnt_next = cnt_inc;
      end
    end else if (col_we) begin
      if (col_done) begin
        cmd_next = CMD_NONE;
        cnt_next = '0;
      end else begin
        cnt_next = cnt_inc;
      end
    end
    if (start_time) begin
      idx_next = 3'd0;
      tgt_next = TGT_TIME;
    end else if (col_done) begin
      idx_next = 3'd0;
      tgt_next = 3'(cmd - CMD_RECV_TIME);
    end else if (out_acc && !last) begin
      idx_next = idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cmd      <= CMD_NONE;
      cnt      <= '0;
      time_vld <= '0;
    end else begin
      state <= state_next;
      cmd   <= cmd_next;
      cnt   <= cnt_next;
      if (time_we) begin
        time_vld[cnt[TAW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    tgt <= tgt_next;
    if (rd_en) begin
      rd_vld <= time_vld[rd_idx[TAW-1:0]];
    end
  end

  cbfr_ram #(
    .WIDTH (8),
    .DEPTH (TIME_RECORD_BYTES)
  ) u_time_ram (
    .clk   (clk),
    .we    (time_we),
    .waddr (cnt[TAW-1:0]),
    .wdata (rx_byte),
    .re    (rd_en),
    .raddr (rd_idx[TAW-1:0]),
    .rdata (t_rdata)
  );

  cbfr_ram #(
    .WIDTH (8),
    .DEPTH (COLOR_BYTES)
  ) u_colour_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (cnt[CAW-1:0]),
    .wdata (col_wdata),
    .re    (rd_en),
    .raddr (rd_idx[CAW-1:0]),
    .rdata (c_rdata)
  );

  assign target     = tgt;
  assign byte_index = idx;
  assign last_byte  = last;
  assign byte_value = (tgt == TGT_TIME) ? (rd_vld ? t_rdata : 8'd0) : c_rdata;

  // input and output sides never overlap
  `CBFR_ASSERT_NOW(a_excl, out_valid, !in_ready)
  // a record keeps flowing until its last byte
  `CBFR_ASSERT_NEXT(a_cont, out_valid && out_ready && !last_byte, out_valid)
  // set-time always starts an emission
  `CBFR_ASSERT_NEXT(a_start, in_valid && in_ready && rx_byte == CMD_SET_TIME,
                    !in_ready && !out_valid)
  // an emitted record starts at index zero
  `CBFR_ASSERT_NEXT(a_first, !out_valid && !in_ready, out_valid && byte_index == 3'd0)

endmodule

// File: test/command_byte_frame_receiver_checker.sv
// Checker for the command byte frame receiver: predicts emitted record bytes and compares them.
module command_byte_frame_receiver_checker
  import cbfr_pkg::*;
#(
  parameter int TIME_RECORD_BYTES = 8,
  parameter int COLOR_BYTES       = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] target,
  input  logic [2:0] byte_index,
  input  logic [7:0] byte_value,
  input  logic       last_byte,
  output int         fail_count,
  output int         records_pending,
  output int         bytes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] tgt;
    logic [2:0] idx;
    logic [7:0] value;
    logic       last;
  } rec_byte_t;

  rec_byte_t  pending_bytes[$];
  logic [7:0] latched_cmd;
  logic [3:0] frame_count;
  logic [7:0] time_store[TIME_RECORD_BYTES];
  logic [7:0] colour_store[COLOR_BYTES];
  int         mismatches;
  int         checked;

  initial begin
    fail_count      = 0;
    records_pending = 0;
    bytes_checked   = 0;
    mismatches      = 0;
    checked         = 0;
    latched_cmd     = CMD_NONE;
    frame_count     = '0;
  end

  // Advance the receiver state by one accepted byte, queueing any record it emits.
  function automatic void predict_byte(input logic [7:0] b);
    rec_byte_t r;
    if (b[7]) begin
      latched_cmd = b;
      frame_count = '0;
      if (b == CMD_SET_TIME) begin
        for (int k = 0; k < TIME_RECORD_BYTES; k++) begin
          r.tgt   = TGT_TIME;
          r.idx   = 3'(k);
          r.value = time_store[k];
          r.last  = (k == TIME_RECORD_BYTES - 1);
          pending_bytes.push_back(r);
        end
      end
      return;
    end
    if (latched_cmd == CMD_RECV_TIME) begin
      if (frame_count < TIME_RECORD_BYTES) begin
        time_store[frame_count] = b;
        frame_count++;
      end
      if (frame_count >= TIME_RECORD_BYTES) begin
        frame_count = '0;
        latched_cmd = CMD_NONE;
      end
    end else if (latched_cmd >= CMD_COLOUR_FIRST && latched_cmd <= CMD_COLOUR_LAST) begin
      if (frame_count < COLOR_BYTES) begin
        // nonzero colour byte d widens to 2d+1
        colour_store[frame_count] = (b == 8'h00) ? 8'h00 : {b[6:0], 1'b1};
        frame_count++;
      end
      if (frame_count >= COLOR_BYTES) begin
        for (int k = 0; k < COLOR_BYTES; k++) begin
          r.tgt   = 3'(latched_cmd - CMD_COLOUR_FIRST + 8'd1);
          r.idx   = 3'(k);
          r.value = colour_store[k];
          r.last  = (k == COLOR_BYTES - 1);
          pending_bytes.push_back(r);
        end
        frame_count = '0;
        latched_cmd = CMD_NONE;
      end
    end
  endfunction

  function automatic void check_byte();
    rec_byte_t want;
    rec_byte_t got;
    got = {target, byte_index, byte_value, last_byte};
    checked++;
    if (pending_bytes.size() == 0) begin
      if (mismatches < 10)
        $display("MISMATCH at %0t: no record byte expected, got target=%0d index=%0d value=%02h last=%0d",
                 $time, got.tgt, got.idx, got.value, got.last);
      mismatches++;
      return;
    end
    want = pending_bytes.pop_front();
    if (got.tgt !== want.tgt || got.idx !== want.idx || got.value !== want.value ||
        got.last !== want.last) begin
      if (mismatches < 10)
        $display("MISMATCH at %0t: expected target=%0d index=%0d value=%02h last=%0d, got target=%0d index=%0d value=%02h last=%0d",
                 $time, want.tgt, want.idx, want.value, want.last,
                 got.tgt, got.idx, got.value, got.last);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      latched_cmd = CMD_NONE;
      frame_count = '0;
      for (int k = 0; k < TIME_RECORD_BYTES; k++) time_store[k] = 8'h00;
      for (int k = 0; k < COLOR_BYTES; k++) colour_store[k] = 8'h00;
      pending_bytes.delete();
    end else begin
      // output first: a byte leaving now belongs to an earlier item
      if (out_valid && out_ready) check_byte();
      if (in_valid && in_ready) predict_byte(rx_byte);
    end
    fail_count      <= mismatches;
    records_pending <= pending_bytes.size();
    bytes_checked   <= checked;
  end

endmodule

// File: test/testbench.sv
// Testbench top for the command byte frame receiver: stimulus, handshake pacing and verdict.
module testbench;
  import cbfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIME_BYTES   = 8;
  localparam int COLOUR_BYTES = 3;
  localparam int RANDOM_ITEMS = 283;   // on top of the directed bytes, about 310 in all
  localparam logic [7:0] CMD_FIRST_UNKNOWN = CMD_COLOUR_LAST + 8'd1;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] target;
  logic [2:0] byte_index;
  logic [7:0] byte_value;
  logic       last_byte;

  int fail_count;
  int records_pending;
  int bytes_checked;

  // Stimulus bookkeeping for the closing summary.
  bit no_idle;          // when set, neither side inserts idle cycles
  int total_items;
  int busy_items;       // items that the receiver acts on
  int set_time_cmds;
  int time_frames;
  int colour_frames;
  int broken_frames;

  command_byte_frame_receiver_top #(
    .TIME_RECORD_BYTES(TIME_BYTES),
    .COLOR_BYTES(COLOUR_BYTES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .target(target),
    .byte_index(byte_index),
    .byte_value(byte_value),
    .last_byte(last_byte)
  );

  command_byte_frame_receiver_checker #(
    .TIME_RECORD_BYTES(TIME_BYTES),
    .COLOR_BYTES(COLOUR_BYTES)
  ) record_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .target(target),
    .byte_index(byte_index),
    .byte_value(byte_value),
    .last_byte(last_byte),
    .fail_count(fail_count),
    .records_pending(records_pending),
    .bytes_checked(bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop, sized for the worst case: an eight-byte record with every byte
  // stalled, and idle cycles before the item.
  initial begin
    #2_000_000;
    $display("Timeout: receiver stopped making progress");
    $display("Simulation FAILED");
    $finish;
  end

  // Record side: before every byte the sink may hold ready low,
  // then keeps it high until a byte is taken.
  initial begin
    int gap;
    out_ready <= 1'b0;
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offer one received byte, after an optional idle gap, and hold it until taken.
  // in_ready is read right after the edge, so it is the value the edge saw.
  task automatic push_byte(input logic [7:0] b, input bit acted_on);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    total_items++;
    if (acted_on) busy_items++;
  endtask

  // Pause the sender until every predicted record byte has come out.
  // The first edge lets the checker's count catch up with the last item.
  task automatic drain_records();
    in_valid <= 1'b0;
    @(posedge clk);
    while (records_pending != 0) @(posedge clk);
  endtask

  // Data byte with the extremes weighted up.
  function automatic logic [7:0] pick_data();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'h7F;
    return 8'($urandom_range(0, 127));
  endfunction

  initial begin
    logic [7:0] directed_bytes[$];
    logic [7:0] cmd;
    int         kind;
    int         len;
    int         next_pause;

    no_idle       = 1'b0;
    total_items   = 0;
    busy_items    = 0;
    set_time_cmds = 0;
    time_frames   = 0;
    colour_frames = 0;
    broken_frames = 0;
    in_valid <= 1'b0;
    rx_byte  <= 8'h00;
    rst      <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part:
    //  - set-time straight after reset dumps the cleared time store
    //  - a full receive-time frame (no output), then set-time reads it back
    //  - hour colour with zero, the widest byte and one
    //  - minute and second frames cut short by the next command, border completes
    //  - unknown commands and the no-command state ignore data
    directed_bytes = '{
      CMD_SET_TIME,
      CMD_RECV_TIME, 8'h00, 8'h7F, 8'h55, 8'h2A, 8'h01, 8'h40, 8'h7E, 8'h3C,
      CMD_SET_TIME,
      CMD_COLOUR_FIRST, 8'h00, 8'h7F, 8'h01,
      CMD_COLOUR_FIRST + 8'd1, 8'h10,
      CMD_COLOUR_FIRST + 8'd2, 8'h20,
      CMD_COLOUR_LAST, 8'h33, 8'h00, 8'h44,
      8'hFF, 8'h12,
      CMD_NONE, 8'h7F
    };
    foreach (directed_bytes[i]) push_byte(directed_bytes[i], 1'b1);
    drain_records();

    // Random part: mostly well-formed frames with random content, plus
    // broken frames, unknown commands and raw noise.
    next_pause = 60;
    while (total_items < RANDOM_ITEMS + 27) begin
      if (busy_items >= next_pause) begin
        drain_records();
        // now and then a stretch with no idling on either side
        no_idle    = ($urandom_range(0, 3) == 0);
        next_pause = next_pause + 60;
      end
      kind = $urandom_range(0, 99);
      if (kind < 28) begin
        push_byte(CMD_RECV_TIME, 1'b1);
        for (int k = 0; k < TIME_BYTES; k++) push_byte(pick_data(), 1'b1);
        time_frames++;
      end else if (kind < 58) begin
        cmd = CMD_COLOUR_FIRST + 8'($urandom_range(0, 3));
        push_byte(cmd, 1'b1);
        for (int k = 0; k < COLOUR_BYTES; k++) push_byte(pick_data(), 1'b1);
        colour_frames++;
      end else if (kind < 72) begin
        push_byte(CMD_SET_TIME, 1'b1);
        set_time_cmds++;
      end else if (kind < 84) begin
        // partial frame: the next command or noise byte takes over
        cmd = 8'($urandom_range(CMD_RECV_TIME, CMD_COLOUR_LAST));
        len = $urandom_range(0, (cmd == CMD_RECV_TIME) ? TIME_BYTES - 1 : COLOUR_BYTES - 1);
        push_byte(cmd, 1'b1);
        for (int k = 0; k < len; k++) push_byte(pick_data(), 1'b1);
        broken_frames++;
      end else if (kind < 90) begin
        cmd = ($urandom_range(0, 3) == 0) ? CMD_NONE
              : 8'($urandom_range(CMD_FIRST_UNKNOWN, 8'hFF));
        push_byte(cmd, 1'b1);
        len = $urandom_range(1, 2);
        for (int k = 0; k < len; k++) push_byte(pick_data(), 1'b0);
      end else begin
        cmd = 8'($urandom_range(0, 255));
        push_byte(cmd, cmd[7]);
      end
    end

    // Wind down: everything predicted must come out, then watch a while for strays.
    no_idle = 1'b0;
    drain_records();
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes: %0d set-time commands, %0d time frames, %0d colour frames, %0d cut short",
             total_items, set_time_cmds, time_frames, colour_frames, broken_frames);
    $display("Compared %0d emitted record bytes; %0d mismatched", bytes_checked, fail_count);
    if (fail_count == 0 && records_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
